// ===== sv/tpi_pkg.sv =====
`timescale 1ns / 1ps

package tpi_pkg;

    localparam int COORD_BITS  = 16;
    localparam int WEIGHT_BITS = 16;
    localparam int W_BITS      = 16;
    localparam int POS_BITS    = W_BITS + 2 * COORD_BITS;
    localparam int RGB_BITS    = 24;
    localparam int CFG_IDX_W   = 3;

    localparam logic [CFG_IDX_W-1:0] REG_V0_POS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_V1_POS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_V2_POS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_V0_RGB = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_V1_RGB = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_V2_RGB = 3'd5;

    localparam int DIFF_W   = COORD_BITS + 1;
    localparam int PROD_W   = 2 * DIFF_W;
    localparam int SUM_W    = PROD_W + 2;
    localparam int WREM_W   = SUM_W + 1;
    localparam int WQ_BITS  = WEIGHT_BITS + 2;
    localparam int WDIV_LAT = WQ_BITS + 1;
    localparam int BARY_W   = WEIGHT_BITS + 2;
    localparam int U_W      = BARY_W + 2;
    localparam int PW_W     = U_W + W_BITS;
    localparam int DW_W     = PW_W + 2;
    localparam int PC_W     = PW_W + 9;
    localparam int NC_W     = PC_W + 2;
    localparam int CDIV_W   = NC_W + 2;
    localparam int CQ_BITS  = 8;
    localparam int CDIV_LAT = CQ_BITS + 1;

    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 64;

    typedef struct packed {
        logic valid;
        logic deg;
        logic neg_s;
        logic neg_t;
        logic sat_s;
        logic sat_t;
    } wside_t;

    typedef struct packed {
        logic                     valid;
        logic                     deg;
        logic                     in_tri;
        logic signed [BARY_W-1:0] s;
        logic signed [BARY_W-1:0] t;
    } bside_t;

endpackage

// ===== sv/triangle_pixel_interpolator_top.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Handshake            Payload
// s_        in         s_tvalid/s_tready    s_tdata: pixel_x, pixel_y
// m_        out        m_tvalid/m_tready    m_tdata: flags, bary_s, bary_t, rgb
// cfg_      in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One request is taken every cycle while no result is held on the output.
// The weight dividers have 18 bit-stages and the color dividers 8.
// Reset clears all valid bits and the vertex registers; no clearing pass is needed.
// A result held on the output stalls the whole pipeline until it is taken.

module triangle_pixel_interpolator_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // pixel_x [15:0], pixel_y [31:16]
    input  logic [tpi_pkg::S_TDATA_W-1:0]     s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // inside_res [0], degenerate [1], bary_s [19:2], bary_t [37:20],
    // red [45:38], green [53:46], blue [61:54], zero [63:62]
    output logic [tpi_pkg::M_TDATA_W-1:0]     m_tdata,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [tpi_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tpi_pkg::POS_BITS-1:0]      cfg_data
);
    import tpi_pkg::*;

    localparam logic signed [BARY_W-1:0] S_MAX = BARY_W'((1 << (WEIGHT_BITS + 1)) - 1);
    localparam int ONE = 1 << WEIGHT_BITS;

    logic [POS_BITS-1:0] pos_reg [0:2];
    logic [RGB_BITS-1:0] rgb_reg [0:2];
    logic                en;

    assign cfg_ready = 1'b1;
    assign en        = ~m_tvalid | m_tready;
    assign s_tready  = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 3; i++) begin
                pos_reg[i] <= '0;
                rgb_reg[i] <= '0;
            end
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_V0_POS: pos_reg[0] <= cfg_data;
                REG_V1_POS: pos_reg[1] <= cfg_data;
                REG_V2_POS: pos_reg[2] <= cfg_data;
                REG_V0_RGB: rgb_reg[0] <= cfg_data[RGB_BITS-1:0];
                REG_V1_RGB: rgb_reg[1] <= cfg_data[RGB_BITS-1:0];
                REG_V2_RGB: rgb_reg[2] <= cfg_data[RGB_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    logic signed [COORD_BITS-1:0] vx [0:2];
    logic signed [COORD_BITS-1:0] vy [0:2];
    logic signed [W_BITS:0]       vw [0:2];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            vx[i] = pos_reg[i][POS_BITS-1 -: COORD_BITS];
            vy[i] = pos_reg[i][W_BITS +: COORD_BITS];
            vw[i] = {1'b0, pos_reg[i][W_BITS-1:0]};
        end
    end

    // Stage 1: edge differences and products.
    logic signed [DIFF_W-1:0] da, db, dc, dd, de, dx, dy;
    logic signed [COORD_BITS-1:0] px, py;

    always_comb begin
        px = s_tdata[COORD_BITS-1:0];
        py = s_tdata[2*COORD_BITS-1:COORD_BITS];
        da = DIFF_W'(vy[1]) - DIFF_W'(vy[2]);
        db = DIFF_W'(vx[2]) - DIFF_W'(vx[1]);
        dc = DIFF_W'(vy[2]) - DIFF_W'(vy[0]);
        dd = DIFF_W'(vx[0]) - DIFF_W'(vx[2]);
        de = DIFF_W'(vy[0]) - DIFF_W'(vy[2]);
        dx = DIFF_W'(px) - DIFF_W'(vx[2]);
        dy = DIFF_W'(py) - DIFF_W'(vy[2]);
    end

    logic                     v1_reg;
    logic signed [PROD_W-1:0] pden0_reg, pden1_reg, pns0_reg, pns1_reg, pnt0_reg, pnt1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_tvalid;
        end
        if (en) begin
            pden0_reg <= PROD_W'(da) * PROD_W'(dd);
            pden1_reg <= PROD_W'(db) * PROD_W'(de);
            pns0_reg  <= PROD_W'(da) * PROD_W'(dx);
            pns1_reg  <= PROD_W'(db) * PROD_W'(dy);
            pnt0_reg  <= PROD_W'(dc) * PROD_W'(dx);
            pnt1_reg  <= PROD_W'(dd) * PROD_W'(dy);
        end
    end

    // Stage 2: sums.
    logic                    v2_reg;
    logic signed [SUM_W-1:0] den_reg, ns_reg, nt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= v1_reg;
        end
        if (en) begin
            den_reg <= SUM_W'(pden0_reg) + SUM_W'(pden1_reg);
            ns_reg  <= SUM_W'(pns0_reg) + SUM_W'(pns1_reg);
            nt_reg  <= SUM_W'(pnt0_reg) + SUM_W'(pnt1_reg);
        end
    end

    // Stage 3: magnitudes and signs.
    wside_t           w3_reg;
    logic [SUM_W-1:0] uden_reg, uns_reg, unt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            w3_reg.valid <= 1'b0;
        end else if (en) begin
            w3_reg.valid <= v2_reg;
        end
        if (en) begin
            w3_reg.deg   <= den_reg == '0;
            w3_reg.neg_s <= ns_reg[SUM_W-1] ^ den_reg[SUM_W-1];
            w3_reg.neg_t <= nt_reg[SUM_W-1] ^ den_reg[SUM_W-1];
            w3_reg.sat_s <= 1'b0;
            w3_reg.sat_t <= 1'b0;
            uden_reg     <= den_reg[SUM_W-1] ? SUM_W'(-den_reg) : SUM_W'(den_reg);
            uns_reg      <= ns_reg[SUM_W-1] ? SUM_W'(-ns_reg) : SUM_W'(ns_reg);
            unt_reg      <= nt_reg[SUM_W-1] ? SUM_W'(-nt_reg) : SUM_W'(nt_reg);
        end
    end

    // Weight dividers with matching side pipeline.
    wside_t             wside_reg [0:WDIV_LAT-1];
    logic [WQ_BITS-1:0] qs, qt;

    tpi_wdiv u_wdiv_s (.aclk(aclk), .en(en), .num(uns_reg), .den(uden_reg), .quo(qs));
    tpi_wdiv u_wdiv_t (.aclk(aclk), .en(en), .num(unt_reg), .den(uden_reg), .quo(qt));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < WDIV_LAT; i++) begin
                wside_reg[i].valid <= 1'b0;
            end
        end else if (en) begin
            wside_reg[0].valid <= w3_reg.valid;
            for (int i = 1; i < WDIV_LAT; i++) begin
                wside_reg[i].valid <= wside_reg[i-1].valid;
            end
        end
        if (en) begin
            wside_reg[0].deg   <= w3_reg.deg;
            wside_reg[0].neg_s <= w3_reg.neg_s;
            wside_reg[0].neg_t <= w3_reg.neg_t;
            wside_reg[0].sat_s <= {1'b0, uns_reg} >= {uden_reg, 1'b0};
            wside_reg[0].sat_t <= {1'b0, unt_reg} >= {uden_reg, 1'b0};
            for (int i = 1; i < WDIV_LAT; i++) begin
                wside_reg[i].deg   <= wside_reg[i-1].deg;
                wside_reg[i].neg_s <= wside_reg[i-1].neg_s;
                wside_reg[i].neg_t <= wside_reg[i-1].neg_t;
                wside_reg[i].sat_s <= wside_reg[i-1].sat_s;
                wside_reg[i].sat_t <= wside_reg[i-1].sat_t;
            end
        end
    end

    // Stage 4: rounding, sign and saturation of s and t; inside test.
    wside_t                  wl;
    logic [WQ_BITS:0]        mag_s, mag_t;
    logic signed [BARY_W-1:0] s_val, t_val;
    logic signed [BARY_W:0]  st_sum;
    logic                    inside_val;

    always_comb begin
        wl    = wside_reg[WDIV_LAT-1];
        mag_s = wl.sat_s ? (WQ_BITS+1)'(1 << (WEIGHT_BITS + 1))
                         : ((WQ_BITS+1)'(qs) + (WQ_BITS+1)'(1)) >> 1;
        mag_t = wl.sat_t ? (WQ_BITS+1)'(1 << (WEIGHT_BITS + 1))
                         : ((WQ_BITS+1)'(qt) + (WQ_BITS+1)'(1)) >> 1;
        if (wl.neg_s) begin
            s_val = BARY_W'(0) - mag_s[BARY_W-1:0];
        end else begin
            s_val = (mag_s > (WQ_BITS+1)'(S_MAX)) ? S_MAX : mag_s[BARY_W-1:0];
        end
        if (wl.neg_t) begin
            t_val = BARY_W'(0) - mag_t[BARY_W-1:0];
        end else begin
            t_val = (mag_t > (WQ_BITS+1)'(S_MAX)) ? S_MAX : mag_t[BARY_W-1:0];
        end
        st_sum     = (BARY_W+1)'(s_val) + (BARY_W+1)'(t_val);
        inside_val = (s_val >= 0) && (s_val <= BARY_W'(ONE))
                  && (t_val >= 0) && (t_val <= BARY_W'(ONE))
                  && (st_sum <= (BARY_W+1)'(ONE));
    end

    bside_t b4_reg, b5_reg, b6_reg, b7_reg, b8_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b4_reg.valid <= 1'b0;
        end else if (en) begin
            b4_reg.valid <= wl.valid;
        end
        if (en) begin
            b4_reg.deg    <= wl.deg;
            b4_reg.in_tri <= inside_val;
            b4_reg.s      <= s_val;
            b4_reg.t      <= t_val;
        end
    end

    // Stage 5: u and w-weighted barycentrics.
    logic signed [U_W-1:0]  u_val;
    logic signed [PW_W-1:0] pw_reg [0:2];

    assign u_val = U_W'(ONE) - U_W'(b4_reg.s) - U_W'(b4_reg.t);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b5_reg.valid <= 1'b0;
        end else if (en) begin
            b5_reg.valid <= b4_reg.valid;
        end
        if (en) begin
            b5_reg.deg    <= b4_reg.deg;
            b5_reg.in_tri <= b4_reg.in_tri;
            b5_reg.s      <= b4_reg.s;
            b5_reg.t      <= b4_reg.t;
            pw_reg[0]     <= PW_W'(b4_reg.s) * PW_W'(vw[0]);
            pw_reg[1]     <= PW_W'(b4_reg.t) * PW_W'(vw[1]);
            pw_reg[2]     <= PW_W'(u_val) * PW_W'(vw[2]);
        end
    end

    // Stage 6: weighted w sum and color products.
    logic signed [DW_W-1:0] dw6_reg;
    logic signed [PC_W-1:0] pc_reg [0:2][0:2];
    logic signed [8:0]      col [0:2][0:2];

    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            for (int i = 0; i < 3; i++) begin
                col[ch][i] = {1'b0, rgb_reg[i][RGB_BITS-1-8*ch -: 8]};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b6_reg.valid <= 1'b0;
        end else if (en) begin
            b6_reg.valid <= b5_reg.valid;
        end
        if (en) begin
            b6_reg.deg    <= b5_reg.deg;
            b6_reg.in_tri <= b5_reg.in_tri;
            b6_reg.s      <= b5_reg.s;
            b6_reg.t      <= b5_reg.t;
            dw6_reg <= DW_W'(pw_reg[0]) + DW_W'(pw_reg[1]) + DW_W'(pw_reg[2]);
            for (int ch = 0; ch < 3; ch++) begin
                for (int i = 0; i < 3; i++) begin
                    pc_reg[ch][i] <= PC_W'(pw_reg[i]) * PC_W'(col[ch][i]);
                end
            end
        end
    end

    // Stage 7: color numerators.
    logic signed [DW_W-1:0] dw7_reg;
    logic signed [NC_W-1:0] nc_reg [0:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b7_reg.valid <= 1'b0;
        end else if (en) begin
            b7_reg.valid <= b6_reg.valid;
        end
        if (en) begin
            b7_reg.deg    <= b6_reg.deg;
            b7_reg.in_tri <= b6_reg.in_tri;
            b7_reg.s      <= b6_reg.s;
            b7_reg.t      <= b6_reg.t;
            dw7_reg       <= dw6_reg;
            for (int ch = 0; ch < 3; ch++) begin
                nc_reg[ch] <= NC_W'(pc_reg[ch][0]) + NC_W'(pc_reg[ch][1])
                            + NC_W'(pc_reg[ch][2]);
            end
        end
    end

    // Stage 8: sign normalization and rounding offset.
    logic signed [NC_W-1:0] nn [0:2];
    logic [DW_W-1:0]        dmag;
    logic [CDIV_W-1:0]      cnum_reg [0:2];
    logic [CDIV_W-1:0]      cden_reg;
    logic [2:0]             czero_reg;

    always_comb begin
        dmag = dw7_reg[DW_W-1] ? DW_W'(-dw7_reg) : DW_W'(dw7_reg);
        for (int ch = 0; ch < 3; ch++) begin
            nn[ch] = dw7_reg[DW_W-1] ? -nc_reg[ch] : nc_reg[ch];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b8_reg.valid <= 1'b0;
        end else if (en) begin
            b8_reg.valid <= b7_reg.valid;
        end
        if (en) begin
            b8_reg.deg    <= b7_reg.deg;
            b8_reg.in_tri <= b7_reg.in_tri;
            b8_reg.s      <= b7_reg.s;
            b8_reg.t      <= b7_reg.t;
            cden_reg      <= CDIV_W'({dmag, 1'b0});
            for (int ch = 0; ch < 3; ch++) begin
                cnum_reg[ch]  <= CDIV_W'({nn[ch], 1'b0}) + CDIV_W'(dmag);
                czero_reg[ch] <= (dmag == '0) || (nn[ch] <= 0);
            end
        end
    end

    // Color dividers with matching side pipeline.
    logic [CQ_BITS-1:0] cq [0:2];
    bside_t             cside_reg [0:CDIV_LAT-1];
    logic [2:0]         cz_reg [0:CDIV_LAT-1];

    for (genvar c = 0; c < 3; c++) begin : g_cdiv
        tpi_cdiv u_cdiv (
            .aclk(aclk), .en(en), .num(cnum_reg[c]), .den(cden_reg), .quo(cq[c])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < CDIV_LAT; i++) begin
                cside_reg[i].valid <= 1'b0;
            end
        end else if (en) begin
            cside_reg[0].valid <= b8_reg.valid;
            for (int i = 1; i < CDIV_LAT; i++) begin
                cside_reg[i].valid <= cside_reg[i-1].valid;
            end
        end
        if (en) begin
            cside_reg[0].deg    <= b8_reg.deg;
            cside_reg[0].in_tri <= b8_reg.in_tri;
            cside_reg[0].s      <= b8_reg.s;
            cside_reg[0].t      <= b8_reg.t;
            cz_reg[0]           <= czero_reg;
            for (int i = 1; i < CDIV_LAT; i++) begin
                cside_reg[i].deg    <= cside_reg[i-1].deg;
                cside_reg[i].in_tri <= cside_reg[i-1].in_tri;
                cside_reg[i].s      <= cside_reg[i-1].s;
                cside_reg[i].t      <= cside_reg[i-1].t;
                cz_reg[i]           <= cz_reg[i-1];
            end
        end
    end

    // Output register.
    bside_t             cl;
    logic [2:0]         czl;
    logic [CQ_BITS-1:0] chan [0:2];
    logic               m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;

    always_comb begin
        cl  = cside_reg[CDIV_LAT-1];
        czl = cz_reg[CDIV_LAT-1];
        for (int ch = 0; ch < 3; ch++) begin
            chan[ch] = (cl.deg || czl[ch]) ? '0 : cq[ch];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            m_tvalid_reg <= cl.valid;
        end
        if (en) begin
            m_tdata_reg <= {2'b00, chan[2], chan[1], chan[0],
                            cl.deg ? BARY_W'(0) : cl.t,
                            cl.deg ? BARY_W'(0) : cl.s,
                            cl.deg, cl.in_tri & ~cl.deg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ===== sv/tpi_wdiv.sv =====
`timescale 1ns / 1ps

module tpi_wdiv (
    input  logic                          aclk,
    input  logic                          en,
    input  logic [tpi_pkg::SUM_W-1:0]     num,
    input  logic [tpi_pkg::SUM_W-1:0]     den,
    output logic [tpi_pkg::WQ_BITS-1:0]   quo
);
    import tpi_pkg::*;

    logic [WREM_W-1:0]  rem_reg [0:WQ_BITS];
    logic [SUM_W-1:0]   div_reg [0:WQ_BITS];
    logic [WQ_BITS-1:0] quo_reg [0:WQ_BITS];

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0] <= {1'b0, num};
            div_reg[0] <= den;
            quo_reg[0] <= '0;
        end
    end

    for (genvar g = 1; g <= WQ_BITS; g++) begin : g_stage
        logic [WREM_W-1:0] trial;
        logic              ge;

        always_comb begin
            trial = (g == 1) ? rem_reg[g-1] : {rem_reg[g-1][WREM_W-2:0], 1'b0};
            ge    = trial >= {1'b0, div_reg[g-1]};
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[g] <= ge ? (trial - {1'b0, div_reg[g-1]}) : trial;
                div_reg[g] <= div_reg[g-1];
                quo_reg[g] <= {quo_reg[g-1][WQ_BITS-2:0], ge};
            end
        end
    end

    assign quo = quo_reg[WQ_BITS];

endmodule

// ===== sv/tpi_cdiv.sv =====
`timescale 1ns / 1ps

module tpi_cdiv (
    input  logic                          aclk,
    input  logic                          en,
    input  logic [tpi_pkg::CDIV_W-1:0]    num,
    input  logic [tpi_pkg::CDIV_W-1:0]    den,
    output logic [tpi_pkg::CQ_BITS-1:0]   quo
);
    import tpi_pkg::*;

    logic [CDIV_W-1:0]  rem_reg [0:CQ_BITS];
    logic [CDIV_W-1:0]  div_reg [0:CQ_BITS];
    logic [CQ_BITS-1:0] quo_reg [0:CQ_BITS];
    logic               sat_reg [0:CQ_BITS];

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0] <= num;
            div_reg[0] <= den;
            quo_reg[0] <= '0;
            sat_reg[0] <= num >= (den << CQ_BITS);
        end
    end

    for (genvar g = 1; g <= CQ_BITS; g++) begin : g_stage
        logic [CDIV_W-1:0] step;
        logic              ge;

        always_comb begin
            step = div_reg[g-1] << (CQ_BITS - g);
            ge   = rem_reg[g-1] >= step;
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[g] <= ge ? (rem_reg[g-1] - step) : rem_reg[g-1];
                div_reg[g] <= div_reg[g-1];
                quo_reg[g] <= {quo_reg[g-1][CQ_BITS-2:0], ge};
                sat_reg[g] <= sat_reg[g-1];
            end
        end
    end

    assign quo = sat_reg[CQ_BITS] ? {CQ_BITS{1'b1}} : quo_reg[CQ_BITS];

endmodule

// ===== bench/tb_triangle_pixel_interpolator_top.sv =====
`timescale 1ns / 1ps

module tb_triangle_pixel_interpolator_top;
    import tpi_pkg::*;

    localparam int STALL_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 60;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE0 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE1 = 3'd7;

    typedef struct {
        bit          in_tri;
        bit          deg;
        logic [17:0] s;
        logic [17:0] t;
        logic [7:0]  r;
        logic [7:0]  g;
        logic [7:0]  b;
    } pixel_result_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [POS_BITS-1:0]  cfg_data = '0;

    logic [POS_BITS-1:0]  vtx_pos [3];
    logic [RGB_BITS-1:0]  vtx_rgb [3];

    logic [S_TDATA_W-1:0] pixel_q [$];
    pixel_result_t        expected_q [$];
    int send_idle = 28;
    int recv_idle = 84;
    int mismatches = 0;
    int results_seen = 0;
    int inside_seen = 0;
    int degenerate_seen = 0;
    int stall_cycles = 0;

    triangle_pixel_interpolator_top dut (.*);

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic longint weight_quot(longint n, longint d);
        bit     neg;
        longint un, ud, q, r, mag, res;
        neg = (n < 0) != (d < 0);
        un = n < 0 ? -n : n;
        ud = d < 0 ? -d : d;
        q = un / ud;
        if (q >= 2) begin
            mag = longint'(2) << WEIGHT_BITS;
        end else begin
            r = un % ud;
            mag = q;
            for (int i = 0; i < WEIGHT_BITS; i++) begin
                r = r << 1;
                mag = mag << 1;
                if (r >= ud) begin
                    r -= ud;
                    mag |= 1;
                end
            end
            r = r << 1;
            if (r >= ud) mag += 1;
        end
        res = neg ? -mag : mag;
        if (res > (longint'(1) << (WEIGHT_BITS + 1)) - 1)
            res = (longint'(1) << (WEIGHT_BITS + 1)) - 1;
        if (res < -(longint'(1) << (WEIGHT_BITS + 1)))
            res = -(longint'(1) << (WEIGHT_BITS + 1));
        return res;
    endfunction

    function automatic logic [7:0] colour_quot(longint n, longint d);
        longint q;
        if (d < 0) begin
            n = -n;
            d = -d;
        end
        if (d == 0 || n <= 0) return 8'd0;
        q = (n * 2 + d) / (d * 2);
        return q > 255 ? 8'd255 : q[7:0];
    endfunction

    function automatic pixel_result_t interpolate_pixel(logic [S_TDATA_W-1:0] req);
        pixel_result_t res;
        longint x [3], y [3], w [3];
        longint px, py, den, ns, nt, s, t, u, one, dw, n;
        longint c [3];
        res = '{default: '0};
        for (int i = 0; i < 3; i++) begin
            w[i] = longint'(vtx_pos[i][15:0]);
            y[i] = longint'($signed(vtx_pos[i][31:16]));
            x[i] = longint'($signed(vtx_pos[i][47:32]));
        end
        px = longint'($signed(req[15:0]));
        py = longint'($signed(req[31:16]));
        den = (y[1] - y[2]) * (x[0] - x[2]) + (x[2] - x[1]) * (y[0] - y[2]);
        if (den == 0) begin
            res.deg = 1'b1;
            return res;
        end
        ns = (y[1] - y[2]) * (px - x[2]) + (x[2] - x[1]) * (py - y[2]);
        nt = (y[2] - y[0]) * (px - x[2]) + (x[0] - x[2]) * (py - y[2]);
        s = weight_quot(ns, den);
        t = weight_quot(nt, den);
        one = longint'(1) << WEIGHT_BITS;
        u = one - s - t;
        res.in_tri = s >= 0 && s <= one && t >= 0 && t <= one && s + t <= one;
        res.s = s[17:0];
        res.t = t[17:0];
        dw = s * w[0] + t * w[1] + u * w[2];
        for (int ch = 0; ch < 3; ch++) begin
            for (int i = 0; i < 3; i++)
                c[i] = longint'(vtx_rgb[i][16 - 8 * ch +: 8]);
            n = s * w[0] * c[0] + t * w[1] * c[1] + u * w[2] * c[2];
            case (ch)
                0: res.r = colour_quot(n, dw);
                1: res.g = colour_quot(n, dw);
                default: res.b = colour_quot(n, dw);
            endcase
        end
        return res;
    endfunction

    // Request driver.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                expected_q.push_back(interpolate_pixel(s_tdata));
            if (!s_tvalid || s_tready) begin
                if (pixel_q.size() > 0 && $urandom_range(99) >= send_idle) begin
                    s_tdata <= pixel_q.pop_front();
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor and checker.
    always @(posedge aclk) begin
        pixel_result_t want;
        pixel_result_t got;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= $urandom_range(99) >= recv_idle;
            if (m_tvalid && m_tready) begin
                got.in_tri = m_tdata[0];
                got.deg = m_tdata[1];
                got.s = m_tdata[19:2];
                got.t = m_tdata[37:20];
                got.r = m_tdata[45:38];
                got.g = m_tdata[53:46];
                got.b = m_tdata[61:54];
                results_seen++;
                if (expected_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: unexpected result %h", m_tdata);
                end else begin
                    want = expected_q.pop_front();
                    inside_seen += want.in_tri;
                    degenerate_seen += want.deg;
                    if (got.in_tri !== want.in_tri || got.deg !== want.deg ||
                        got.s !== want.s || got.t !== want.t || got.r !== want.r ||
                        got.g !== want.g || got.b !== want.b) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"ERROR: result %0d expected in=%b deg=%b s=%h t=%h ",
                                      "rgb=%h/%h/%h, got in=%b deg=%b s=%h t=%h rgb=%h/%h/%h"},
                                     results_seen, want.in_tri, want.deg, want.s, want.t,
                                     want.r, want.g, want.b, got.in_tri, got.deg, got.s,
                                     got.t, got.r, got.g, got.b);
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            stall_cycles <= 0;
        end else if (aresetn) begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [POS_BITS-1:0] value);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_V0_POS, REG_V1_POS, REG_V2_POS: vtx_pos[idx] = value;
            REG_V0_RGB, REG_V1_RGB, REG_V2_RGB: vtx_rgb[idx - REG_V0_RGB] = value[23:0];
            default: ;
        endcase
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pixel_q.size() > 0 || s_tvalid || expected_q.size() > 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [S_TDATA_W-1:0] pack_pixel(int px, int py);
        return {py[15:0], px[15:0]};
    endfunction

    function automatic int pick_coord(int mode);
        case ($urandom_range(mode == 1 ? 3 : 9))
            0: return -32768;
            1: return 32767;
            default: return int'($urandom_range(32767)) - 16384;
        endcase
    endfunction

    initial begin
        int vx [3], vy [3];
        int lo_x, hi_x, lo_y, hi_y, mode;
        logic [15:0] w;
        vtx_pos = '{default: '0};
        vtx_rgb = '{default: '0};
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset registers describe a degenerate triangle.
        pixel_q.push_back(pack_pixel(0, 0));
        pixel_q.push_back(pack_pixel(-32768, 32767));
        pixel_q.push_back(pack_pixel(32767, -32768));
        wait_drained();

        // Unit right triangle with full-range colors and unequal w.
        write_reg(REG_V0_POS, {16'sd0, 16'sd0, 16'h1000});
        write_reg(REG_V1_POS, {16'sd16384, 16'sd0, 16'h2000});
        write_reg(REG_V2_POS, {16'sd0, 16'sd16384, 16'hFFFF});
        write_reg(REG_V0_RGB, {24'hABCDEF, 24'hFF0000});
        write_reg(REG_V1_RGB, 48'h00FF00);
        write_reg(REG_V2_RGB, 48'h0000FF);
        write_reg(REG_SPARE0, 48'hFFFF_FFFF_FFFF);
        write_reg(REG_SPARE1, 48'h1234_5678_9ABC);
        foreach (vx[i]) begin
            vx[i] = i == 1 ? 16384 : 0;
            vy[i] = i == 2 ? 16384 : 0;
            pixel_q.push_back(pack_pixel(vx[i], vy[i]));
        end
        pixel_q.push_back(pack_pixel(8192, 8192));
        pixel_q.push_back(pack_pixel(8192, 0));
        pixel_q.push_back(pack_pixel(0, 8192));
        pixel_q.push_back(pack_pixel(5461, 5461));
        pixel_q.push_back(pack_pixel(8193, 8192));
        pixel_q.push_back(pack_pixel(-1, 0));
        pixel_q.push_back(pack_pixel(0, -1));
        pixel_q.push_back(pack_pixel(-32768, -32768));
        pixel_q.push_back(pack_pixel(32767, 32767));
        pixel_q.push_back(pack_pixel(-32768, 32767));
        pixel_q.push_back(pack_pixel(32767, -32768));
        pixel_q.push_back(pack_pixel(3, 16380));
        wait_drained();

        for (int phase = 0; phase < 12; phase++) begin
            send_idle = phase < 4 ? 28 : (phase < 8 ? 84 : 0);
            recv_idle = phase < 4 ? 84 : (phase < 8 ? 28 : 0);
            // 0 ordinary, 1 extreme coordinates, 2 collinear, 3 all w zero.
            mode = phase % 4;
            foreach (vx[i]) begin
                vx[i] = pick_coord(mode);
                vy[i] = pick_coord(mode);
            end
            if (mode == 2) begin
                vx[2] = vx[0] + (vx[1] - vx[0]) / 2;
                vy[2] = vy[0] + (vy[1] - vy[0]) / 2;
                if ((vx[1] - vx[0]) % 2 != 0 || (vy[1] - vy[0]) % 2 != 0) begin
                    vx[2] = vx[0];
                    vy[2] = vy[0];
                end
            end
            for (int i = 0; i < 3; i++) begin
                case ($urandom_range(5))
                    0: w = 16'h0000;
                    1: w = 16'hFFFF;
                    default: w = 16'($urandom_range(16'hFFFF));
                endcase
                if (mode == 3) w = 16'h0000;
                write_reg(REG_V0_POS + CFG_IDX_W'(i), {vx[i][15:0], vy[i][15:0], w});
                write_reg(REG_V0_RGB + CFG_IDX_W'(i), POS_BITS'({$urandom(), $urandom()}));
            end
            write_reg(phase % 2 == 0 ? REG_SPARE0 : REG_SPARE1,
                      POS_BITS'({$urandom(), $urandom()}));
            lo_x = vx[0] < vx[1] ? vx[0] : vx[1];
            lo_x = vx[2] < lo_x ? vx[2] : lo_x;
            hi_x = vx[0] > vx[1] ? vx[0] : vx[1];
            hi_x = vx[2] > hi_x ? vx[2] : hi_x;
            lo_y = vy[0] < vy[1] ? vy[0] : vy[1];
            lo_y = vy[2] < lo_y ? vy[2] : lo_y;
            hi_y = vy[0] > vy[1] ? vy[0] : vy[1];
            hi_y = vy[2] > hi_y ? vy[2] : hi_y;
            for (int k = 0; k < 75; k++) begin
                if ($urandom_range(99) < 80)
                    pixel_q.push_back(pack_pixel(lo_x + $urandom_range(hi_x - lo_x),
                                                 lo_y + $urandom_range(hi_y - lo_y)));
                else
                    pixel_q.push_back($urandom());
                if (phase == 5 && k == 37) begin
                    while (pixel_q.size() > 0 || s_tvalid || expected_q.size() > 0)
                        @(posedge aclk);
                end
            end
            wait_drained();
        end

        $display("Checked %0d pixels over 14 triangle setups: %0d inside, %0d degenerate.",
                 results_seen, inside_seen, degenerate_seen);
        $display("Idle patterns covered sender-light, receiver-light and back-to-back traffic.");
        if (mismatches == 0 && expected_q.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ===== triangle_pixel_interpolator_top.f =====
sv/tpi_pkg.sv
sv/tpi_wdiv.sv
sv/tpi_cdiv.sv
sv/triangle_pixel_interpolator_top.sv
bench/tb_triangle_pixel_interpolator_top.sv
